[sv/two_set_nearest_visit_query_core_defines.svh]
// Assertion macros for the block's top-level RTL.
`ifndef TWO_SET_NEAREST_VISIT_QUERY_CORE_DEFINES_SVH
`define TWO_SET_NEAREST_VISIT_QUERY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset.
`define TSNV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tsnv assertion failed");
// Checked at every edge, reset included.
`define TSNV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("tsnv assertion failed");
`else
`define TSNV_ASSERT(lbl, clk, rstn, prop)
`define TSNV_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[sv/tsnv_pkg.sv]
package tsnv_pkg;

  localparam int unsigned DEPTH   = 4096;
  localparam int unsigned POS_W   = 34;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned SLOT_W  = 12;
  localparam int unsigned CNT_W   = 13;
  // search index covers 0 .. n+2
  localparam int unsigned IDX_W   = $clog2(DEPTH + 3);
  localparam int unsigned DIST_W  = 37;
  localparam int unsigned CAND_W  = DIST_W + 2;
  // signed working width for x - entry and entry - x
  localparam int unsigned ARITH_W = 36;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_WR_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_B = 2'd1;

  localparam logic signed [ARITH_W-1:0] FAR_LEFT  = -36'sd10000000000;
  localparam logic signed [ARITH_W-1:0] FAR_RIGHT = 36'sd20000000000;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] x;
    logic [IDX_W-1:0] n;
  } srch_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] right;
  } srch_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] la;
    logic [DIST_W-1:0] ra;
    logic [DIST_W-1:0] lb;
    logic [DIST_W-1:0] rb;
  } comb_in_t;

  // Table entry with far marks at index 0 and beyond n.
  function automatic logic signed [ARITH_W-1:0] marked(
    input logic [IDX_W-1:0] idx,
    input logic [IDX_W-1:0] n,
    input logic [POS_W-1:0] data
  );
    logic signed [ARITH_W-1:0] r;
    if (idx == '0) begin
      r = FAR_LEFT;
    end else if (idx > n) begin
      r = FAR_RIGHT;
    end else begin
      r = $signed(ARITH_W'(data));
    end
    return r;
  endfunction

  // Clamp a count register to the table depth.
  function automatic logic [IDX_W-1:0] sat_count(input logic [CNT_W-1:0] cnt);
    logic [IDX_W-1:0] r;
    if (32'(cnt) > DEPTH) begin
      r = IDX_W'(DEPTH);
    end else begin
      r = IDX_W'(cnt);
    end
    return r;
  endfunction

endpackage

[sv/tsnv_mem.sv]
// Table RAM: one write port, two registered read ports.
module tsnv_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [tsnv_pkg::ADDR_W-1:0]   wr_addr_i,
  input  logic [tsnv_pkg::POS_W-1:0]    wr_data_i,
  input  tsnv_pkg::mem_rd_t             rd_a_i,
  input  tsnv_pkg::mem_rd_t             rd_b_i,
  output logic [tsnv_pkg::POS_W-1:0]    rd_a_data_o,
  output logic [tsnv_pkg::POS_W-1:0]    rd_b_data_o
);

  logic [tsnv_pkg::POS_W-1:0] mem_q [tsnv_pkg::DEPTH];
  logic [tsnv_pkg::POS_W-1:0] rd_a_q;
  logic [tsnv_pkg::POS_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_a_i.en) begin
      rd_a_q <= mem_q[rd_a_i.addr];
    end
    if (rd_b_i.en) begin
      rd_b_q <= mem_q[rd_b_i.addr];
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

[sv/tsnv_search.sv]
// Two lower-bound searches over one table: key x+1 (left) and key x (right).
// Each probe is a RAM read, then a compare; then one fetch of both neighbor entries.
module tsnv_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tsnv_pkg::srch_req_t         req_i,
  output tsnv_pkg::srch_rsp_t         rsp_o,
  output tsnv_pkg::mem_rd_t           rd_l_o,
  output tsnv_pkg::mem_rd_t           rd_r_o,
  input  logic [tsnv_pkg::POS_W-1:0]  rd_l_data_i,
  input  logic [tsnv_pkg::POS_W-1:0]  rd_r_data_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  logic [1:0] state_q, state_d;
  logic [tsnv_pkg::IDX_W-1:0] lo_l_q, lo_l_d, hi_l_q, hi_l_d;
  logic [tsnv_pkg::IDX_W-1:0] lo_r_q, lo_r_d, hi_r_q, hi_r_d;
  logic [tsnv_pkg::IDX_W-1:0] mid_l_q, mid_l_d, mid_r_q, mid_r_d;
  logic [tsnv_pkg::IDX_W-1:0] n_q, n_d;
  logic [tsnv_pkg::POS_W-1:0] x_q, x_d;
  logic [tsnv_pkg::DIST_W-1:0] left_q, left_d, right_q, right_d;
  logic done_q, done_d;

  logic act_l, act_r;
  logic [tsnv_pkg::IDX_W:0] sum_l, sum_r;
  logic [tsnv_pkg::IDX_W-1:0] fetch_l;
  logic signed [tsnv_pkg::ARITH_W-1:0] x_s, e_l, e_r, d_l, d_r;
  logic pred_l, pred_r;

  assign act_l   = lo_l_q < hi_l_q;
  assign act_r   = lo_r_q < hi_r_q;
  assign sum_l   = {1'b0, lo_l_q} + {1'b0, hi_l_q};
  assign sum_r   = {1'b0, lo_r_q} + {1'b0, hi_r_q};
  assign fetch_l = (lo_l_q == '0) ? '0 : lo_l_q - 1'b1;

  assign x_s    = $signed(tsnv_pkg::ARITH_W'(x_q));
  assign e_l    = tsnv_pkg::marked(mid_l_q, n_q, rd_l_data_i);
  assign e_r    = tsnv_pkg::marked(mid_r_q, n_q, rd_r_data_i);
  // entry < x+1 for the left search, entry < x for the right search
  assign pred_l = e_l <= x_s;
  assign pred_r = e_r < x_s;
  assign d_l    = x_s - e_l;
  assign d_r    = e_r - x_s;

  always_comb begin
    state_d = state_q;
    lo_l_d  = lo_l_q;
    hi_l_d  = hi_l_q;
    lo_r_d  = lo_r_q;
    hi_r_d  = hi_r_q;
    mid_l_d = mid_l_q;
    mid_r_d = mid_r_q;
    n_d     = n_q;
    x_d     = x_q;
    left_d  = left_q;
    right_d = right_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          lo_l_d  = '0;
          lo_r_d  = '0;
          hi_l_d  = req_i.n + tsnv_pkg::IDX_W'(2);
          hi_r_d  = req_i.n + tsnv_pkg::IDX_W'(2);
          n_d     = req_i.n;
          x_d     = req_i.x;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (act_l || act_r) begin
          mid_l_d = sum_l[tsnv_pkg::IDX_W:1];
          mid_r_d = sum_r[tsnv_pkg::IDX_W:1];
          state_d = S_CMP;
        end else begin
          mid_l_d = fetch_l;
          mid_r_d = lo_r_q;
          state_d = S_FINAL;
        end
      end
      S_CMP: begin
        if (act_l) begin
          if (pred_l) begin
            lo_l_d = mid_l_q + 1'b1;
          end else begin
            hi_l_d = mid_l_q;
          end
        end
        if (act_r) begin
          if (pred_r) begin
            lo_r_d = mid_r_q + 1'b1;
          end else begin
            hi_r_d = mid_r_q;
          end
        end
        state_d = S_ISSUE;
      end
      S_FINAL: begin
        left_d = d_l[tsnv_pkg::ARITH_W-1] ? '0
                 : tsnv_pkg::DIST_W'(d_l[tsnv_pkg::ARITH_W-2:0]);
        if (mid_r_q > n_q + 1'b1) begin
          right_d = tsnv_pkg::DIST_MAX;
        end else begin
          right_d = d_r[tsnv_pkg::ARITH_W-1] ? '0
                    : tsnv_pkg::DIST_W'(d_r[tsnv_pkg::ARITH_W-2:0]);
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // read the entry below the index (index 0 is the far-left mark)
  assign rd_l_o.en   = state_q == S_ISSUE;
  assign rd_l_o.addr = tsnv_pkg::ADDR_W'(mid_l_d - 1'b1);
  assign rd_r_o.en   = state_q == S_ISSUE;
  assign rd_r_o.addr = tsnv_pkg::ADDR_W'(mid_r_d - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_l_q  <= lo_l_d;
    hi_l_q  <= hi_l_d;
    lo_r_q  <= lo_r_d;
    hi_r_q  <= hi_r_d;
    mid_l_q <= mid_l_d;
    mid_r_q <= mid_r_d;
    n_q     <= n_d;
    x_q     <= x_d;
    left_q  <= left_d;
    right_q <= right_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.left  = left_q;
  assign rsp_o.right = right_q;

endmodule

[sv/tsnv_combine.sv]
// Six visiting costs, then a two-level minimum and saturation.
module tsnv_combine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsnv_pkg::comb_in_t            in_i,
  output logic                          res_valid_o,
  output logic [tsnv_pkg::DIST_W-1:0]   res_distance_o
);

  logic v1_q, v2_q, v3_q;
  logic [tsnv_pkg::CAND_W-1:0] c_q [6];
  logic [tsnv_pkg::CAND_W-1:0] m_q [3];
  logic [tsnv_pkg::DIST_W-1:0] res_q;

  logic [tsnv_pkg::CAND_W-1:0] la, ra, lb, rb, m01, m_fin;

  assign la = tsnv_pkg::CAND_W'(in_i.la);
  assign ra = tsnv_pkg::CAND_W'(in_i.ra);
  assign lb = tsnv_pkg::CAND_W'(in_i.lb);
  assign rb = tsnv_pkg::CAND_W'(in_i.rb);

  assign m01   = (m_q[0] < m_q[1]) ? m_q[0] : m_q[1];
  assign m_fin = (m01 < m_q[2]) ? m01 : m_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid) begin
      c_q[0] <= (la > lb) ? la : lb;
      c_q[1] <= (ra > rb) ? ra : rb;
      c_q[2] <= (la << 1) + rb;
      c_q[3] <= (lb << 1) + ra;
      c_q[4] <= la + (rb << 1);
      c_q[5] <= lb + (ra << 1);
    end
    if (v1_q) begin
      m_q[0] <= (c_q[0] < c_q[1]) ? c_q[0] : c_q[1];
      m_q[1] <= (c_q[2] < c_q[3]) ? c_q[2] : c_q[3];
      m_q[2] <= (c_q[4] < c_q[5]) ? c_q[4] : c_q[5];
    end
    if (v2_q) begin
      res_q <= (m_fin < tsnv_pkg::CAND_W'(tsnv_pkg::DIST_MAX))
               ? m_fin[tsnv_pkg::DIST_W-1:0] : tsnv_pkg::DIST_MAX;
    end
  end

  assign res_valid_o    = v3_q;
  assign res_distance_o = res_q;

endmodule

[sv/two_set_nearest_visit_query_core.sv]
// Nearest A/B visit query over two sorted position tables.
// Input channel (in_valid_i / in_stall_o): opcode 0 writes position_i into
// table A at slot_i, opcode 1 into table B, opcode 2 queries point
// position_i, opcode 3 is dropped. Writes give no item on the output.
// Output channel (out_valid_o / out_stall_i): one distance item per query.
// Config channel (cfg_valid_i / cfg_ready_o, always ready): index 0 sets
// count_a, index 1 count_b; other indexes are dropped. Write only when idle.
// A query's time from accept to out_valid_o is set by the binary-search
// probe loop over n, the larger table count clamped to 4096: each probe is
// a RAM read plus a compare, on each table's two read ports.
// One item at a time: in_stall_o is high from a query's accept until its
// result reaches the output register; writes do not raise in_stall_o.
// A held output item does not block new items; a finished query waits in
// the combine stage until the output register frees up.
// Reset: counts return to 1, control clears; table RAMs are not cleared.
module two_set_nearest_visit_query_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tsnv_pkg::OP_W-1:0]        opcode_i,
  input  logic [tsnv_pkg::SLOT_W-1:0]      slot_i,
  input  logic [tsnv_pkg::POS_W-1:0]       position_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [tsnv_pkg::DIST_W-1:0]      distance_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tsnv_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tsnv_pkg::CNT_W-1:0]       cfg_data_i
);

`include "two_set_nearest_visit_query_core_defines.svh"

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SEARCH  = 2'd1;
  localparam logic [1:0] ST_COMBINE = 2'd2;
  localparam logic [1:0] ST_DRAIN   = 2'd3;

  logic [1:0] state_q, state_d;
  logic [tsnv_pkg::CNT_W-1:0] count_a_q, count_b_q;
  logic got_a_q, got_a_d, got_b_q, got_b_d;
  logic out_valid_q, out_valid_d;
  logic [tsnv_pkg::DIST_W-1:0] out_dist_q;
  logic out_load;
  logic comb_go;

  logic in_accept, slot_ok, we_a, we_b, is_query;
  tsnv_pkg::srch_req_t req_a, req_b;
  tsnv_pkg::srch_rsp_t rsp_a, rsp_b;
  tsnv_pkg::mem_rd_t   rd_al, rd_ar, rd_bl, rd_br;
  logic [tsnv_pkg::POS_W-1:0] dat_al, dat_ar, dat_bl, dat_br;
  tsnv_pkg::comb_in_t  comb_in;
  logic res_valid;
  logic [tsnv_pkg::DIST_W-1:0] res_distance;

  // ---- input side: one item at a time ----
  assign in_stall_o = state_q != ST_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_ok    = 32'(slot_i) < tsnv_pkg::DEPTH;
  assign we_a       = in_accept && (opcode_i == tsnv_pkg::OP_WR_A) && slot_ok;
  assign we_b       = in_accept && (opcode_i == tsnv_pkg::OP_WR_B) && slot_ok;
  assign is_query   = in_accept && (opcode_i == tsnv_pkg::OP_QUERY);

  // ---- config registers ----
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q <= tsnv_pkg::CNT_W'(1);
      count_b_q <= tsnv_pkg::CNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == tsnv_pkg::CFG_COUNT_A) begin
        count_a_q <= cfg_data_i;
      end
      if (cfg_index_i == tsnv_pkg::CFG_COUNT_B) begin
        count_b_q <= cfg_data_i;
      end
    end
  end

  // ---- tables and searches ----
  assign req_a.start = is_query;
  assign req_a.x     = position_i;
  assign req_a.n     = tsnv_pkg::sat_count(count_a_q);
  assign req_b.start = is_query;
  assign req_b.x     = position_i;
  assign req_b.n     = tsnv_pkg::sat_count(count_b_q);

  tsnv_mem u_mem_a (
    .clk_i       (clk_i),
    .we_i        (we_a),
    .wr_addr_i   (tsnv_pkg::ADDR_W'(slot_i)),
    .wr_data_i   (position_i),
    .rd_a_i      (rd_al),
    .rd_b_i      (rd_ar),
    .rd_a_data_o (dat_al),
    .rd_b_data_o (dat_ar)
  );

  tsnv_mem u_mem_b (
    .clk_i       (clk_i),
    .we_i        (we_b),
    .wr_addr_i   (tsnv_pkg::ADDR_W'(slot_i)),
    .wr_data_i   (position_i),
    .rd_a_i      (rd_bl),
    .rd_b_i      (rd_br),
    .rd_a_data_o (dat_bl),
    .rd_b_data_o (dat_br)
  );

  tsnv_search u_search_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_a),
    .rsp_o       (rsp_a),
    .rd_l_o      (rd_al),
    .rd_r_o      (rd_ar),
    .rd_l_data_i (dat_al),
    .rd_r_data_i (dat_ar)
  );

  tsnv_search u_search_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_b),
    .rsp_o       (rsp_b),
    .rd_l_o      (rd_bl),
    .rd_r_o      (rd_br),
    .rd_l_data_i (dat_bl),
    .rd_r_data_i (dat_br)
  );

  // ---- cost combine ----
  // search results stay registered in the search units until the next query
  assign comb_in.valid = comb_go;
  assign comb_in.la    = rsp_a.left;
  assign comb_in.ra    = rsp_a.right;
  assign comb_in.lb    = rsp_b.left;
  assign comb_in.rb    = rsp_b.right;

  tsnv_combine u_combine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (comb_in),
    .res_valid_o    (res_valid),
    .res_distance_o (res_distance)
  );

  // ---- control ----
  always_comb begin
    state_d  = state_q;
    got_a_d  = got_a_q || rsp_a.done;
    got_b_d  = got_b_q || rsp_b.done;
    comb_go  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        got_a_d = 1'b0;
        got_b_d = 1'b0;
        if (is_query) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // tables with different counts can finish on different cycles
        if (got_a_d && got_b_d) begin
          comb_go = 1'b1;
          got_a_d = 1'b0;
          got_b_d = 1'b0;
          state_d = ST_COMBINE;
        end
      end
      ST_COMBINE: begin
        if (res_valid) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- output register ----
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      got_a_q     <= 1'b0;
      got_b_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      got_a_q     <= got_a_d;
      got_b_q     <= got_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_dist_q <= res_distance;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = out_dist_q;

  // ---- checks ----
  `TSNV_ASSERT(a_wr_only_idle, clk_i, rst_ni, (we_a || we_b) |-> (state_q == ST_IDLE))
  `TSNV_ASSERT(a_done_in_search, clk_i, rst_ni, (rsp_a.done || rsp_b.done) |-> (state_q == ST_SEARCH))
  `TSNV_ASSERT(a_res_in_combine, clk_i, rst_ni, res_valid |-> (state_q == ST_COMBINE))
  `TSNV_ASSERT_ALWAYS(a_out_from_drain, clk_i, $rose(out_valid_q) |-> ($past(state_q) == ST_DRAIN))

endmodule
